FILE: hw/rtl/u8c_pkg.sv
// ============================================================================
// u8c_pkg - shared types and constants for the UTF-8 code point counter
// Item classes passed from the front end to the back end, the end status
// codes, the saturation cap and the helpers for counting and range checks.
// ============================================================================
package u8c_pkg;

  // Largest string length the counters are meant for
  localparam longint unsigned MAX_STRING_BYTES = 64'd65535;

  // Counters hold at the smaller of MAX_STRING_BYTES and the 16-bit range
  localparam logic [16:0] COUNT_CAP =
    17'((MAX_STRING_BYTES < 64'd65535) ? MAX_STRING_BYTES : 64'd65535);

  // Code point limits
  localparam logic [20:0] MAX_CODE_POINT = 21'h10FFFF;
  localparam logic [20:0] SURR_LO        = 21'h00D800;
  localparam logic [20:0] SURR_HI        = 21'h00DFFF;

  // Queue between front and back end
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Byte classes, decided in the front end
  typedef enum logic [2:0] {
    K_ASCII = 3'b001,
    K_CONT  = 3'b010,
    K_LEAD  = 3'b100
  } u8c_kind_t;

  // End status codes, also the running stop state of the back end
  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_INVALID = 2'd1,
    ST_LIMIT   = 2'd2
  } u8c_status_t;

  // One classified byte as held in the queue
  typedef struct packed {
    u8c_kind_t   kind;
    logic [2:0]  lead_len;   // continuation bytes announced by a lead byte
    logic [5:0]  bits;       // payload bits of the byte
    logic        last;
    logic        use_limit;
    logic [15:0] limit;
  } u8c_item_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } u8c_qstat_t;

  // Saturating counter step
  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [2:0] b);
    logic [16:0] sum;
    sum = {1'b0, a} + {14'd0, b};
    if (sum > COUNT_CAP) begin
      sum = COUNT_CAP;
    end
    return sum[15:0];
  endfunction

  // Smallest value a sequence of the given continuation count may encode
  function automatic logic [20:0] shortest_value(input logic [1:0] n);
    logic [20:0] v;
    unique case (n)
      2'd0:    v = 21'h000000;
      2'd1:    v = 21'h000080;
      2'd2:    v = 21'h000800;
      default: v = 21'h010000;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/u8c_front.sv
// ============================================================================
// u8c_front - input side of the UTF-8 code point counter
// Takes bytes from the stream, classifies each one and pushes the
// classified item into the queue while the queue has room.
// ============================================================================
module u8c_front (
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [23:0]         in_tdata,   // [7:0] data_byte, [23:8] code_point_limit
  input  logic                in_tlast,   // last_byte
  input  logic                in_tuser,   // use_limit
  input  u8c_pkg::u8c_qstat_t qstat,
  output logic                push,
  output u8c_pkg::u8c_item_t  push_item
);

  logic [7:0] b;
  logic [2:0] n;
  logic       run;

  assign b = in_tdata[7:0];

  // Ones following the lead marker, bit 6 downwards, at most seven
  always_comb begin
    n   = 3'd0;
    run = 1'b1;
    for (int i = 6; i >= 0; i--) begin
      if (run && b[i]) begin
        n = n + 3'd1;
      end else begin
        run = 1'b0;
      end
    end
  end

  // Classification
  always_comb begin
    push_item           = '0;
    push_item.last      = in_tlast;
    push_item.use_limit = in_tuser;
    push_item.limit     = in_tdata[23:8];
    push_item.lead_len  = n;
    priority if (!b[7]) begin
      push_item.kind = u8c_pkg::K_ASCII;
      push_item.bits = b[5:0];
    end else if (!b[6]) begin
      push_item.kind = u8c_pkg::K_CONT;
      push_item.bits = b[5:0];
    end else begin
      push_item.kind = u8c_pkg::K_LEAD;
      push_item.bits = b[5:0] & (6'h3F >> n);
    end
  end

  // Handshake
  assign in_tready = !qstat.full;
  assign push      = in_tvalid && !qstat.full;

endmodule

FILE: hw/rtl/u8c_queue.sv
// ============================================================================
// u8c_queue - short queue of classified bytes
// Register based first-in first-out queue that lets the front and back end
// stall independently.
// ============================================================================
module u8c_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  u8c_pkg::u8c_item_t  push_item,
  input  logic                pop,
  output u8c_pkg::u8c_item_t  head_item,
  output u8c_pkg::u8c_qstat_t qstat
);

  u8c_pkg::u8c_item_t              mem_r [u8c_pkg::QUEUE_DEPTH];
  logic [u8c_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [u8c_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [u8c_pkg::QPTR_W:0]        count_r, count_nxt;

  // Status and head
  assign qstat.full  = (count_r == (u8c_pkg::QPTR_W+1)'(u8c_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count_r == '0);
  assign head_item   = mem_r[rd_ptr_r];

  // Pointer update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: hw/rtl/u8c_back.sv
// ============================================================================
// u8c_back - decoding side of the UTF-8 code point counter
// Pops one classified byte per cycle while not stalled, tracks the sequence in
// progress, validates code points and registers the result on the last byte.
// ============================================================================
module u8c_back (
  input  logic                clk,
  input  logic                rst_n,
  input  u8c_pkg::u8c_item_t  head_item,
  input  u8c_pkg::u8c_qstat_t qstat,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,  // [15:0] code_points, [31:16] prefix_bytes
  output logic [1:0]          out_tuser   // end_status
);

  // Decoder state
  logic [2:0]            pend_r,    pend_nxt;
  logic [2:0]            seqlen_r,  seqlen_nxt;
  logic [14:0]           acc_r,     acc_nxt;
  logic [15:0]           bytes_r,   bytes_nxt;
  logic [15:0]           cnt_r,     cnt_nxt;
  u8c_pkg::u8c_status_t  stop_r,    stop_nxt;
  logic                  lim_en_r,  lim_en_nxt;
  logic [15:0]           lim_r,     lim_nxt;
  logic                  start_r,   start_nxt;

  // Result register
  logic                  ovalid_r,  ovalid_nxt;
  logic [31:0]           odata_r,   odata_nxt;
  logic [1:0]            ouser_r,   ouser_nxt;

  logic [20:0]           v;
  logic                  ok;

  // Pop while the result register can take a result
  assign pop = !qstat.empty && (!ovalid_r || out_tready);

  // Code point with the current continuation payload appended
  assign v = {acc_r, head_item.bits};

  always_comb begin
    ok = (seqlen_r <= 3'd3) && (v >= u8c_pkg::shortest_value(seqlen_r[1:0])) &&
         (v <= u8c_pkg::MAX_CODE_POINT) &&
         !((v >= u8c_pkg::SURR_LO) && (v <= u8c_pkg::SURR_HI));
  end

  // Decode step
  always_comb begin
    pend_nxt   = pend_r;
    seqlen_nxt = seqlen_r;
    acc_nxt    = acc_r;
    bytes_nxt  = bytes_r;
    cnt_nxt    = cnt_r;
    stop_nxt   = stop_r;
    lim_en_nxt = lim_en_r;
    lim_nxt    = lim_r;
    start_nxt  = start_r;
    if (pop) begin
      // First byte of a string: clear and sample the limit
      if (start_r) begin
        pend_nxt   = '0;
        seqlen_nxt = '0;
        acc_nxt    = '0;
        bytes_nxt  = '0;
        cnt_nxt    = '0;
        stop_nxt   = u8c_pkg::ST_VALID;
        lim_en_nxt = head_item.use_limit;
        lim_nxt    = head_item.limit;
      end
      start_nxt = head_item.last;
      if (stop_nxt == u8c_pkg::ST_VALID) begin
        if (pend_nxt == '0) begin
          // Byte where a new code point starts
          priority if (lim_en_nxt && (cnt_nxt >= lim_nxt)) begin
            stop_nxt = u8c_pkg::ST_LIMIT;
          end else if (head_item.kind == u8c_pkg::K_ASCII) begin
            cnt_nxt   = u8c_pkg::sat_add(cnt_nxt, 3'd1);
            bytes_nxt = u8c_pkg::sat_add(bytes_nxt, 3'd1);
          end else if (head_item.kind == u8c_pkg::K_CONT) begin
            stop_nxt = u8c_pkg::ST_INVALID;
          end else begin
            seqlen_nxt = head_item.lead_len;
            pend_nxt   = head_item.lead_len;
            acc_nxt    = {9'd0, head_item.bits};
            if (head_item.last) begin
              stop_nxt = u8c_pkg::ST_INVALID;
            end
          end
        end else begin
          // Continuation expected; start_r is low here, so v sees the live state
          if (head_item.kind != u8c_pkg::K_CONT) begin
            stop_nxt = u8c_pkg::ST_INVALID;
          end else begin
            acc_nxt  = v[14:0];
            pend_nxt = pend_r - 3'd1;
            if (pend_nxt == '0) begin
              if (ok) begin
                cnt_nxt   = u8c_pkg::sat_add(cnt_r, 3'd1);
                bytes_nxt = u8c_pkg::sat_add(bytes_r, seqlen_r + 3'd1);
              end else begin
                stop_nxt = u8c_pkg::ST_INVALID;
              end
            end else if (head_item.last) begin
              stop_nxt = u8c_pkg::ST_INVALID;
            end
          end
        end
      end
    end
  end

  // Result register
  always_comb begin
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    ouser_nxt  = ouser_r;
    if (pop && head_item.last) begin
      ovalid_nxt = 1'b1;
      odata_nxt  = {bytes_nxt, cnt_nxt};
      ouser_nxt  = stop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      seqlen_r <= '0;
      acc_r    <= '0;
      bytes_r  <= '0;
      cnt_r    <= '0;
      stop_r   <= u8c_pkg::ST_VALID;
      lim_en_r <= 1'b0;
      lim_r    <= '0;
      start_r  <= 1'b1;
      ovalid_r <= 1'b0;
    end else begin
      pend_r   <= pend_nxt;
      seqlen_r <= seqlen_nxt;
      acc_r    <= acc_nxt;
      bytes_r  <= bytes_nxt;
      cnt_r    <= cnt_nxt;
      stop_r   <= stop_nxt;
      lim_en_r <= lim_en_nxt;
      lim_r    <= lim_nxt;
      start_r  <= start_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

endmodule

FILE: hw/rtl/utf8_validating_code_point_counter_top.sv
// ============================================================================
// utf8_validating_code_point_counter_top - UTF-8 validating code point counter
// Decodes a byte stream as UTF-8 and, on the last byte of each string,
// reports code points decoded, prefix length in bytes and an end status.
// ============================================================================
//
//  Channel | Ports   | tdata fields (low bit up)          | tuser / tlast
//  --------+---------+------------------------------------+--------------------
//  input   | in_*    | data_byte[7:0], code_point_limit   | use_limit / last_byte
//  result  | out_*   | code_points[15:0], prefix_bytes    | end_status / -
//
//  One byte per cycle while results drain; back end decodes one byte a cycle.
//  out_tvalid rises after the last byte passes the queue and result register.
//  Synchronous active-low reset empties the 4-entry queue and the result slot.
//  in_tready drops only when the queue is full, i.e. after out_tready stalls.
//  A string yields exactly one result, on its byte with in_tlast set.
//
module utf8_validating_code_point_counter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] data_byte, [23:8] code_point_limit
  input  logic        in_tlast,   // last_byte
  input  logic        in_tuser,   // use_limit
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] code_points, [31:16] prefix_bytes
  output logic [1:0]  out_tuser   // end_status
);

  logic                push;
  logic                pop;
  u8c_pkg::u8c_item_t  push_item;
  u8c_pkg::u8c_item_t  head_item;
  u8c_pkg::u8c_qstat_t qstat;

  // Front end: accept and classify
  u8c_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  // Queue between the two ends
  u8c_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .qstat     (qstat)
  );

  // Back end: decode, validate, report
  u8c_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_item  (head_item),
    .qstat      (qstat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: hw/rtl/u8c_checker.sv
// ============================================================================
// u8c_checker - port level checks for the UTF-8 code point counter
// Watches the top level ports and flags results that cannot be right.
// ============================================================================
module u8c_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // End status is one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == u8c_pkg::ST_VALID) || (out_tuser == u8c_pkg::ST_INVALID) ||
                   (out_tuser == u8c_pkg::ST_LIMIT))
    else $error("undefined end status");

  // Every code point takes at least one byte
  a_bytes_ge_points: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:16] >= out_tdata[15:0])
    else $error("prefix shorter than code point count");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Input is held off only after a stalled result
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("input held off without a stalled result");

endmodule

bind utf8_validating_code_point_counter_top u8c_checker u_u8c_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the UTF-8 validating code point counter
// Streams strings of bytes into the counter: a short directed set of edge
// cases and a bulk of random mostly well-formed strings with planted faults.
// A behavioural decoder predicts each string's result; results are checked
// field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

  // Cycles with no transaction on either side before the run is abandoned
  localparam int unsigned STALL_LIMIT   = 3000;
  // Receiver hold-off length and the result count that triggers it
  localparam int unsigned LONG_HOLD     = 250;
  localparam int unsigned HOLD_AT_COUNT = 30;
  localparam int unsigned RANDOM_ITEMS  = 1000;

  // One byte as queued for the driver
  typedef struct packed {
    logic        hold;      // wait for all results before offering this byte
    logic [15:0] limit;
    logic        use_lim;
    logic        last;
    logic [7:0]  data;
  } str_byte_t;

  // Outcome of one string
  typedef struct packed {
    logic [15:0]          code_points;
    logic [15:0]          prefix_bytes;
    u8c_pkg::u8c_status_t status;
  } str_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [7:0] data_byte, [23:8] code_point_limit
  logic        in_tlast;   // last_byte
  logic        in_tuser;   // use_limit
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [15:0] code_points, [31:16] prefix_bytes
  logic [1:0]  out_tuser;  // end_status

  str_byte_t   byte_q[$];
  str_result_t result_q[$];
  logic [7:0]  str_bytes[$];

  int unsigned error_count;
  int unsigned results_seen;
  int unsigned idle_cycles;
  int unsigned send_gap;
  int unsigned ready_gap;
  int unsigned hold_left;
  int          tx_burst;
  int          rx_burst;
  logic        long_hold_done;

  // Decoder state mirrored by the bench
  logic [2:0]           pend_cont;
  logic [2:0]           seq_len;
  logic [31:0]          acc_val;
  logic [15:0]          acc_bytes;
  logic [15:0]          cp_count;
  u8c_pkg::u8c_status_t stop;
  logic                 lim_en;
  logic [15:0]          lim_val;
  logic                 at_start;

  utf8_validating_code_point_counter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic logic [15:0] cap_add(input logic [15:0] a, input int unsigned inc);
    logic [16:0] s;
    s = {1'b0, a} + 17'(inc);
    if (s > u8c_pkg::COUNT_CAP) begin
      s = u8c_pkg::COUNT_CAP;
    end
    return s[15:0];
  endfunction

  // Smallest value allowed for a given number of continuation bytes
  function automatic logic [31:0] lowest_for(input logic [2:0] ncont);
    case (ncont)
      3'd1:    return 32'h80;
      3'd2:    return 32'h800;
      3'd3:    return 32'h10000;
      default: return 32'h0;
    endcase
  endfunction

  task automatic decode_byte(input str_byte_t it);
    logic [2:0]  n;
    logic        run;
    logic [31:0] v;
    logic        ok;
    str_result_t res;
    if (at_start) begin
      pend_cont = '0;
      seq_len   = '0;
      acc_val   = '0;
      acc_bytes = '0;
      cp_count  = '0;
      stop      = u8c_pkg::ST_VALID;
      lim_en    = it.use_lim;
      lim_val   = it.limit;
    end
    at_start = it.last;

    if (stop == u8c_pkg::ST_VALID) begin
      if (pend_cont == 3'd0) begin
        if (lim_en && (cp_count >= lim_val)) begin
          stop = u8c_pkg::ST_LIMIT;
        end else if (!it.data[7]) begin
          cp_count  = cap_add(cp_count, 1);
          acc_bytes = cap_add(acc_bytes, 1);
        end else if (!it.data[6]) begin
          // continuation byte where a code point should start
          stop = u8c_pkg::ST_INVALID;
        end else begin
          n   = '0;
          run = 1'b1;
          for (int k = 5; k >= 0; k--) begin
            if (run && it.data[k]) n = n + 3'd1;
            else run = 1'b0;
          end
          if (run) n = n + 3'd0;
          // all seven low bits set on a lead byte announces seven
          if (it.data[6:0] == 7'h7F) n = 3'd7;
          else n = n + 3'd1;
          seq_len   = n;
          pend_cont = n;
          acc_val   = 32'(it.data) & (32'h3F >> n);
          if (it.last) stop = u8c_pkg::ST_INVALID;
        end
      end else begin
        if (it.data[7:6] != 2'b10) begin
          stop = u8c_pkg::ST_INVALID;
        end else begin
          acc_val   = (acc_val << 6) | 32'(it.data[5:0]);
          pend_cont = pend_cont - 3'd1;
          if (pend_cont == 3'd0) begin
            v  = acc_val;
            ok = (seq_len <= 3'd3) && (v >= lowest_for(seq_len)) &&
                 (v <= 32'(u8c_pkg::MAX_CODE_POINT)) &&
                 !((v >= 32'(u8c_pkg::SURR_LO)) && (v <= 32'(u8c_pkg::SURR_HI)));
            if (ok) begin
              cp_count  = cap_add(cp_count, 1);
              acc_bytes = cap_add(acc_bytes, 32'(seq_len) + 1);
            end else begin
              stop = u8c_pkg::ST_INVALID;
            end
          end else if (it.last) begin
            stop = u8c_pkg::ST_INVALID;
          end
        end
      end
    end

    if (it.last) begin
      res.code_points  = cp_count;
      res.prefix_bytes = acc_bytes;
      res.status       = stop;
      result_q.push_back(res);
    end
  endtask

  // --------------------------------------------------------------------------
  // String building
  // --------------------------------------------------------------------------

  task automatic put_b(input logic [7:0] b);
    str_bytes.push_back(b);
  endtask

  // Encode a value in a form with the given number of continuation bytes
  task automatic put_form(input int unsigned cp, input int unsigned ncont);
    logic [7:0] lead;
    if (ncont == 0) begin
      str_bytes.push_back(8'(cp & 32'h7F));
    end else begin
      lead = 8'((32'hFF << (7 - ncont)) | ((cp >> (6 * ncont)) & (32'h3F >> ncont)));
      str_bytes.push_back(lead);
      for (int k = ncont - 1; k >= 0; k--) begin
        str_bytes.push_back(8'(32'h80 | ((cp >> (6 * k)) & 32'h3F)));
      end
    end
  endtask

  // Shortest form, whether or not the value is legal
  task automatic put_cp(input int unsigned cp);
    int unsigned ncont;
    ncont = (cp < 32'h80) ? 0 : (cp < 32'h800) ? 1 : (cp < 32'h10000) ? 2 : 3;
    put_form(cp, ncont);
  endtask

  function automatic int unsigned legal_cp(input int unsigned ncont);
    int unsigned v;
    case (ncont)
      0:       v = $urandom_range(0, 32'h7F);
      1:       v = $urandom_range(32'h80, 32'h7FF);
      2: begin
        v = $urandom_range(32'h800, 32'hFFFF);
        if (v >= 32'hD800 && v <= 32'hDFFF) v = v ^ 32'h1000;
      end
      default: v = $urandom_range(32'h10000, 32'h10FFFF);
    endcase
    return v;
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    return (r < 40) ? 0 : (r < 60) ? 1 : (r < 85) ? 2 : 3;
  endfunction

  // Move the built string into the driver queue; limit fields only count on
  // the first byte, so later bytes carry random values there
  task automatic commit_string(input logic use_lim, input logic [15:0] limit,
                               input logic hold);
    str_byte_t it;
    for (int i = 0; i < str_bytes.size(); i++) begin
      it.data    = str_bytes[i];
      it.last    = (i == str_bytes.size() - 1);
      it.use_lim = (i == 0) ? use_lim : 1'($urandom_range(0, 1));
      it.limit   = (i == 0) ? limit : 16'($urandom_range(0, 16'hFFFF));
      it.hold    = (i == 0) ? hold : 1'b0;
      byte_q.push_back(it);
    end
    str_bytes.delete();
  endtask

  // One code point spoilt in one of several ways
  task automatic put_fault();
    int unsigned n;
    int unsigned cut;
    case ($urandom_range(0, 6))
      0: put_b(8'($urandom_range(0, 255)));
      1: begin
        // overlong form
        n = $urandom_range(1, 3);
        put_form($urandom_range(0, lowest_for(3'(n)) - 1), n);
      end
      2: put_cp($urandom_range(32'hD800, 32'hDFFF));
      3: put_cp($urandom_range(32'h110000, 32'h1FFFFF));
      4: put_b(8'($urandom_range(8'h80, 8'hBF)));
      5: put_form($urandom, $urandom_range(4, 7));
      default: begin
        // continuation bytes cut short
        n   = $urandom_range(1, 3);
        put_form(legal_cp(n), n);
        cut = $urandom_range(1, n);
        repeat (cut) void'(str_bytes.pop_back());
      end
    endcase
  endtask

  task automatic build_directed();
    put_b(8'h00); put_b(8'h7F);              commit_string(1'b0, 16'd0, 1'b0);
    put_cp(32'h80); put_cp(32'h10FFFF);      commit_string(1'b0, 16'd0, 1'b0);
    put_cp(32'hD800);                        commit_string(1'b0, 16'd0, 1'b0);
    put_cp(32'h110000);                      commit_string(1'b0, 16'd0, 1'b0);
    put_form(32'h7F, 1);                     commit_string(1'b0, 16'd0, 1'b0);
    put_b(8'h80);                            commit_string(1'b0, 16'd0, 1'b0);
    put_b(8'hFF);                            commit_string(1'b0, 16'd0, 1'b0);
    put_b(8'hE2); put_b(8'h82);              commit_string(1'b0, 16'd0, 1'b0);
    put_b(8'hC3); put_b(8'h41);              commit_string(1'b0, 16'd0, 1'b0);
    // limit of zero stops at once
    put_b(8'h41);                            commit_string(1'b1, 16'd0, 1'b0);
    // string ending exactly on the limit stays valid
    put_b(8'h41); put_cp(32'h20AC);          commit_string(1'b1, 16'd2, 1'b0);
    put_b(8'h41); put_b(8'h42);              commit_string(1'b1, 16'd1, 1'b0);
    put_b(8'h30);                            commit_string(1'b1, 16'hFFFF, 1'b0);
    put_b(8'h31);                            commit_string(1'b0, 16'd0, 1'b0);
  endtask

  task automatic build_random();
    int unsigned n_items;
    int unsigned str_idx;
    int unsigned ncp;
    int          bad_at;
    logic        use_lim;
    logic [15:0] limit;
    n_items = 0;
    str_idx = 0;
    while (n_items < RANDOM_ITEMS) begin
      ncp    = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
      bad_at = ($urandom_range(0, 99) < 75) ? -1 : int'($urandom_range(0, ncp - 1));
      for (int i = 0; i < ncp; i++) begin
        if (i == bad_at) put_fault();
        else put_cp(legal_cp(pick_len()));
      end
      use_lim = ($urandom_range(0, 99) < 25);
      limit   = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                            : 16'($urandom_range(0, ncp + 1));
      n_items += str_bytes.size();
      commit_string(use_lim, limit, (str_idx == 12) || (str_idx == 100));
      str_idx++;
    end
  endtask

  // Mostly back to back, some short gaps, a few long ones, and bursts
  function automatic int unsigned pick_gap(inout int burst);
    int unsigned r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst = $urandom_range(30, 100);
      return 0;
    end
    return (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3)
         : (r < 97) ? $urandom_range(4, 10) : $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic check_result();
    str_result_t exp;
    if (result_q.size() == 0) begin
      report_mismatch("result with nothing outstanding", out_tdata, 0);
    end else begin
      exp = result_q.pop_front();
      if (out_tdata[15:0] != exp.code_points)
        report_mismatch("code_points", out_tdata[15:0], exp.code_points);
      if (out_tdata[31:16] != exp.prefix_bytes)
        report_mismatch("prefix_bytes", out_tdata[31:16], exp.prefix_bytes);
      if (out_tuser != exp.status)
        report_mismatch("end_status", out_tuser, exp.status);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers the front byte; a held byte waits for all results
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_byte(byte_q.pop_front());
        send_gap = pick_gap(tx_burst);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (byte_q.size() != 0 && !(byte_q[0].hold && result_q.size() != 0)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {byte_q[0].limit, byte_q[0].data};
        in_tlast  <= byte_q[0].last;
        in_tuser  <= byte_q[0].use_lim;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result transaction and drives out_tready
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : recv_proc
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_gap = 0;
      hold_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_result();
        results_seen++;
        ready_gap = pick_gap(rx_burst);
      end else if (out_tready && $urandom_range(0, 99) < 4) begin
        ready_gap = pick_gap(rx_burst);
      end
      // one long hold-off so the input queue fills and backs up
      if (!long_hold_done && results_seen == HOLD_AT_COUNT) begin
        hold_left      = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin : watchdog_proc
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stim_proc
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tlast       = 1'b0;
    in_tuser       = 1'b0;
    out_tready     = 1'b0;
    error_count    = 0;
    results_seen   = 0;
    idle_cycles    = 0;
    tx_burst       = 0;
    rx_burst       = 0;
    long_hold_done = 1'b0;
    pend_cont      = '0;
    seq_len        = '0;
    acc_val        = '0;
    acc_bytes      = '0;
    cp_count       = '0;
    stop           = u8c_pkg::ST_VALID;
    lim_en         = 1'b0;
    lim_val        = '0;
    at_start       = 1'b1;

    build_directed();
    build_random();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || result_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0 && result_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/u8c_pkg.sv
hw/rtl/u8c_front.sv
hw/rtl/u8c_queue.sv
hw/rtl/u8c_back.sv
hw/rtl/utf8_validating_code_point_counter_top.sv
hw/rtl/u8c_checker.sv
sim/tb_top.sv
